// ----- hw/rtl/dae_pkg.sv -----
// Shared types and constants of the DNS answer address extractor.
// No dependencies; every other file of the block except dae_if imports this package.
`default_nettype none

package dae_pkg;

    // Byte queue between the classifier and the parser
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // DNS field constants
    localparam logic [7:0]  PTR_MASK    = 8'hC0;
    localparam logic [7:0]  RCODE_MASK  = 8'h0F;
    localparam logic [15:0] TYPE_A      = 16'd1;
    localparam logic [15:0] TYPE_AAAA   = 16'd28;
    localparam logic [15:0] LEN_A       = 16'd4;
    localparam logic [15:0] LEN_AAAA    = 16'd16;
    localparam logic [3:0]  HDR_RCODE   = 4'd3;
    localparam logic [3:0]  HDR_QD_HI   = 4'd4;
    localparam logic [3:0]  HDR_QD_LO   = 4'd5;
    localparam logic [3:0]  HDR_AN_HI   = 4'd6;
    localparam logic [3:0]  HDR_AN_LO   = 4'd7;
    localparam logic [3:0]  HDR_LAST    = 4'd11;
    localparam logic [3:0]  QFIX_LAST   = 4'd3;
    localparam logic [3:0]  AFIX_TYPE_HI = 4'd0;
    localparam logic [3:0]  AFIX_TYPE_LO = 4'd1;
    localparam logic [3:0]  AFIX_LEN_HI = 4'd8;
    localparam logic [3:0]  AFIX_LEN_LO = 4'd9;
    localparam int          ADDR_BYTES  = 16;

    // Classified packet byte as it travels through the queue
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       is_ptr;
        logic       is_zero;
        logic       rcode_nz;
    } t_beat;

    // Queue status seen by the classifier and the top level
    typedef struct packed {
        logic               empty;
        logic               full;
        logic [Q_CNT_W-1:0] count;
    } t_q_stat;

    // Parser phases, one-hot
    typedef enum logic [8:0] {
        PH_HEADER = 9'b000000001,
        PH_LABEL  = 9'b000000010,
        PH_SKIP   = 9'b000000100,
        PH_PTR    = 9'b000001000,
        PH_QFIXED = 9'b000010000,
        PH_AFIXED = 9'b000100000,
        PH_RDSKIP = 9'b001000000,
        PH_ADDR   = 9'b010000000,
        PH_DONE   = 9'b100000000
    } t_phase;

    // Packet outcome; the first three double as the status codes
    typedef enum logic [1:0] {
        OUT_NONE = 2'd0,
        OUT_V4   = 2'd1,
        OUT_V6   = 2'd2,
        OUT_FAIL = 2'd3
    } t_outcome;

endpackage

`default_nettype wire

// ----- hw/rtl/dae_if.sv -----
// Valid/ready channel interfaces of the DNS answer address extractor.
// No dependencies.
`default_nettype none

interface dae_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dae_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] addr_high;
    logic [63:0] addr_low;

    modport source (output valid, output status, output addr_high, output addr_low,
                    input ready);
    modport sink   (input valid, input status, input addr_high, input addr_low,
                    output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/dae_front.sv -----
// Front end: accepts packet bytes and tags them for the parser.
// Depends on dae_pkg and dae_in_if.
`default_nettype none

module dae_front import dae_pkg::*; (
    dae_in_if.sink  i_in,
    input  t_q_stat i_q_stat,
    output logic    o_push,
    output t_beat   o_beat
);

    assign i_in.ready = !i_q_stat.full;
    assign o_push     = i_in.valid && !i_q_stat.full;

    always_comb begin
        o_beat.data     = i_in.data_byte;
        o_beat.last     = i_in.last_byte;
        o_beat.is_ptr   = (i_in.data_byte & PTR_MASK) == PTR_MASK;
        o_beat.is_zero  = i_in.data_byte == 8'd0;
        o_beat.rcode_nz = (i_in.data_byte & RCODE_MASK) != 8'd0;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/dae_fifo.sv -----
// Short byte queue between the classifier and the parser.
// Depends on dae_pkg.
`default_nettype none

module dae_fifo import dae_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_beat   i_beat,
    input  logic    i_pop,
    output t_beat   o_head,
    output t_q_stat o_stat
);

    t_beat              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, n_wr;
    logic [Q_PTR_W-1:0] r_rd, n_rd;
    logic [Q_CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wr  = i_push ? r_wr + Q_PTR_W'(1) : r_wr;
        n_rd  = i_pop  ? r_rd + Q_PTR_W'(1) : r_rd;
        n_cnt = r_cnt + Q_CNT_W'(i_push) - Q_CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_beat;
        end
    end

    assign o_head       = r_mem[r_rd];
    assign o_stat.empty = r_cnt == '0;
    assign o_stat.full  = r_cnt == Q_CNT_W'(Q_DEPTH);
    assign o_stat.count = r_cnt;

endmodule

`default_nettype wire

// ----- hw/rtl/dae_back.sv -----
// Back end: walks the DNS message one byte per cycle (a last byte waits while a
// result is untaken), registers the result; depends on dae_pkg and dae_out_if.
`default_nettype none

module dae_back import dae_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_beat   i_head,
    input  logic    i_head_valid,
    output logic    o_pop,
    dae_out_if.source o_out
);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_hpos, n_hpos;
    logic [15:0] r_qleft, n_qleft;
    logic [15:0] r_aleft, n_aleft;
    logic [15:0] r_skip, n_skip;
    logic [15:0] r_rtype, n_rtype;
    logic [15:0] r_dlen, n_dlen;
    logic [3:0]  r_fidx, n_fidx;
    t_outcome    r_outc, n_outc;
    logic [7:0]  r_addr [ADDR_BYTES];
    logic [7:0]  n_addr [ADDR_BYTES];

    logic        r_ovalid;
    logic [1:0]  r_status;
    logic [63:0] r_hi;
    logic [63:0] r_lo;

    logic        slot_free;
    logic        emit;
    logic        found;
    logic [7:0]  b;
    logic [15:0] skip_dec;
    logic [15:0] dlen_now;
    logic [15:0] aleft_dec;
    logic [15:0] qleft_dec;
    logic [3:0]  aidx;
    logic [63:0] res_hi;
    logic [63:0] res_lo;

    assign slot_free = !r_ovalid || o_out.ready;
    assign o_pop     = i_head_valid && (!i_head.last || slot_free);
    assign emit      = o_pop && i_head.last;
    assign b         = i_head.data;
    assign skip_dec  = r_skip - 16'd1;
    assign dlen_now  = {r_dlen[15:8], b};
    assign aleft_dec = r_aleft - 16'd1;
    assign qleft_dec = r_qleft - 16'd1;
    assign aidx      = 4'(r_dlen - r_skip);

    always_comb begin
        n_phase = r_phase;
        n_hpos  = r_hpos;
        n_qleft = r_qleft;
        n_aleft = r_aleft;
        n_skip  = r_skip;
        n_rtype = r_rtype;
        n_dlen  = r_dlen;
        n_fidx  = r_fidx;
        n_outc  = r_outc;
        for (int i = 0; i < ADDR_BYTES; i++) begin
            n_addr[i] = r_addr[i];
        end

        if (o_pop) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_hpos == HDR_RCODE && i_head.rcode_nz) begin
                        n_outc  = OUT_FAIL;
                        n_phase = PH_DONE;
                    end else begin
                        if (r_hpos == HDR_QD_HI) n_qleft = {b, r_qleft[7:0]};
                        if (r_hpos == HDR_QD_LO) n_qleft = {r_qleft[15:8], b};
                        if (r_hpos == HDR_AN_HI) n_aleft = {b, r_aleft[7:0]};
                        if (r_hpos == HDR_AN_LO) n_aleft = {r_aleft[15:8], b};
                        if (r_hpos >= HDR_LAST) begin
                            // Counts are complete by now
                            if (r_qleft != '0 || r_aleft != '0) begin
                                n_phase = PH_LABEL;
                            end else begin
                                n_phase = PH_DONE;
                                n_outc  = OUT_FAIL;
                            end
                        end else begin
                            n_hpos = r_hpos + 4'd1;
                        end
                    end
                end
                PH_LABEL: begin
                    priority if (i_head.is_ptr) begin
                        n_phase = PH_PTR;
                    end else if (i_head.is_zero) begin
                        n_fidx  = '0;
                        n_phase = (r_qleft != '0) ? PH_QFIXED : PH_AFIXED;
                    end else begin
                        n_skip  = {8'd0, b};
                        n_phase = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    n_skip = skip_dec;
                    if (skip_dec == '0) n_phase = PH_LABEL;
                end
                PH_PTR: begin
                    n_fidx  = '0;
                    n_phase = (r_qleft != '0) ? PH_QFIXED : PH_AFIXED;
                end
                PH_QFIXED: begin
                    n_fidx = r_fidx + 4'd1;
                    if (r_fidx >= QFIX_LAST) begin
                        n_qleft = qleft_dec;
                        if (qleft_dec != '0 || r_aleft != '0) begin
                            n_phase = PH_LABEL;
                        end else begin
                            n_phase = PH_DONE;
                            n_outc  = OUT_FAIL;
                        end
                    end
                end
                PH_AFIXED: begin
                    if (r_fidx == AFIX_TYPE_HI) n_rtype = {b, r_rtype[7:0]};
                    if (r_fidx == AFIX_TYPE_LO) n_rtype = {r_rtype[15:8], b};
                    if (r_fidx == AFIX_LEN_HI)  n_dlen  = {b, r_dlen[7:0]};
                    if (r_fidx == AFIX_LEN_LO)  n_dlen  = dlen_now;
                    if (r_fidx < AFIX_LEN_LO) begin
                        n_fidx = r_fidx + 4'd1;
                    end else if ((r_rtype == TYPE_A && dlen_now == LEN_A) ||
                                 (r_rtype == TYPE_AAAA && dlen_now == LEN_AAAA)) begin
                        n_skip  = dlen_now;
                        n_phase = PH_ADDR;
                        for (int i = 0; i < ADDR_BYTES; i++) begin
                            n_addr[i] = '0;
                        end
                    end else if (dlen_now == '0) begin
                        n_aleft = aleft_dec;
                        if (r_qleft != '0 || aleft_dec != '0) begin
                            n_phase = PH_LABEL;
                        end else begin
                            n_phase = PH_DONE;
                            n_outc  = OUT_FAIL;
                        end
                    end else begin
                        n_skip  = dlen_now;
                        n_phase = PH_RDSKIP;
                    end
                end
                PH_RDSKIP: begin
                    n_skip = skip_dec;
                    if (skip_dec == '0) begin
                        n_aleft = aleft_dec;
                        if (r_qleft != '0 || aleft_dec != '0) begin
                            n_phase = PH_LABEL;
                        end else begin
                            n_phase = PH_DONE;
                            n_outc  = OUT_FAIL;
                        end
                    end
                end
                PH_ADDR: begin
                    n_addr[aidx] = b;
                    n_skip       = skip_dec;
                    if (skip_dec == '0) begin
                        n_outc  = (r_dlen == LEN_A) ? OUT_V4 : OUT_V6;
                        n_phase = PH_DONE;
                    end
                end
                PH_DONE: begin
                    // Drop everything up to the end of the packet
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
        end
    end

    // Result of the packet as it stands after the current byte
    assign found = n_outc == OUT_V4 || n_outc == OUT_V6;

    always_comb begin
        for (int i = 0; i < ADDR_BYTES / 2; i++) begin
            res_hi[63 - 8*i -: 8] = found ? n_addr[i] : 8'd0;
            res_lo[63 - 8*i -: 8] = found ? n_addr[i + ADDR_BYTES / 2] : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || emit) begin
            r_phase <= PH_HEADER;
            r_hpos  <= '0;
            r_qleft <= '0;
            r_aleft <= '0;
            r_skip  <= '0;
            r_rtype <= '0;
            r_dlen  <= '0;
            r_fidx  <= '0;
            r_outc  <= OUT_NONE;
        end else begin
            r_phase <= n_phase;
            r_hpos  <= n_hpos;
            r_qleft <= n_qleft;
            r_aleft <= n_aleft;
            r_skip  <= n_skip;
            r_rtype <= n_rtype;
            r_dlen  <= n_dlen;
            r_fidx  <= n_fidx;
            r_outc  <= n_outc;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ADDR_BYTES; i++) begin
            r_addr[i] <= n_addr[i];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_status <= found ? n_outc : OUT_NONE;
            r_hi     <= res_hi;
            r_lo     <= res_lo;
        end
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.status    = r_status;
    assign o_out.addr_high = r_hi;
    assign o_out.addr_low  = r_lo;

endmodule

`default_nettype wire

// ----- hw/rtl/dns_answer_address_extractor.sv -----
// Top level of the DNS answer address extractor.
// Depends on dae_pkg, dae_if, dae_front, dae_fifo and dae_back.
`default_nettype none

// Channel   Dir  Beat payload                         Handshake
// i_in      in   data_byte[7:0], last_byte            valid/ready
// o_out     out  status[1:0], addr_high[63:0],        valid/ready
//                addr_low[63:0]
//
// One byte per cycle is sustained while results are taken; the parser consumes
// one queued byte per cycle unless a last byte waits on the output register. A
// result is registered once the parser pops the packet's last byte from the queue.
// Reset is synchronous, active low, and empties the queue and parser.
// A full four-entry byte queue drops ready on i_in; only a last byte waits
// in the queue while the output register holds an untaken result.
//
// Flow: the front end tags each byte (pointer, zero, rcode bits) and pushes
// it into the queue; the back end walks header, questions and answers and
// captures the first A record with 4 data bytes or AAAA with 16.
module dns_answer_address_extractor import dae_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dae_in_if.sink    i_in,
    dae_out_if.source o_out
);

    logic    push;
    logic    pop;
    t_beat   push_beat;
    t_beat   head;
    t_q_stat q_stat;

    dae_front u_front (
        .i_in     (i_in),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_beat   (push_beat)
    );

    dae_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_beat  (push_beat),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    dae_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (!q_stat.empty),
        .o_pop        (pop),
        .o_out        (o_out)
    );

    // Never pop an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("byte queue popped while empty");

    // A last byte must not overwrite a result still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && head.last) |-> (!o_out.valid || o_out.ready))
        else $error("result overwritten before it was taken");

    // Queue occupancy rises by one on a push without a pop
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (push && !pop) |=> (q_stat.count == $past(q_stat.count) + 1'b1))
        else $error("queue count out of step with pushes");

    // Reset leaves the queue empty and no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (q_stat.empty && !o_out.valid))
        else $error("state not cleared by reset");

endmodule

`default_nettype wire

// ----- bench/dns_answer_address_extractor_tb.sv -----
// Self-checking bench for the DNS answer address extractor.
// Depends on dae_pkg, dae_if and the block's top level; drives packets byte by byte.
`timescale 1ns / 100ps

module dns_answer_address_extractor_tb;
    import dae_pkg::*;

    localparam int STALL_LIMIT = 3000;  // cycles with no beat on either side
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 20;
    localparam int RAND_BYTES = 1100;
    localparam int HOLD_PACKET = 2;     // packet at which the receiver holds off
    localparam int QUIET_FROM = 300;    // byte count where idling stops
    localparam int QUIET_TO = 650;      // byte count where idling resumes
    localparam int MAX_REPORTS = 10;

    // One result beat as the block presents it
    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
    } t_addr_result;

    // One directed byte; typed rows carry a status that is plain at a glance
    typedef struct packed {
        logic [7:0] b;
        logic       last;
        logic       typed;
        t_outcome   st;
    } t_stim_row;

    localparam int N_ROWS = 25;
    localparam t_stim_row STIM_ROWS [N_ROWS] = '{
        // packet of a single byte
        '{8'h00, 1'b1, 1'b1, OUT_NONE},
        // header cut short before the rcode byte
        '{8'hFF, 1'b0, 1'b0, OUT_NONE},
        '{8'hFF, 1'b0, 1'b0, OUT_NONE},
        '{8'hFF, 1'b1, 1'b1, OUT_NONE},
        // rcode all ones, then the packet goes on
        '{8'h12, 1'b0, 1'b0, OUT_NONE},
        '{8'h34, 1'b0, 1'b0, OUT_NONE},
        '{8'h81, 1'b0, 1'b0, OUT_NONE},
        '{8'h8F, 1'b0, 1'b0, OUT_NONE},
        '{8'h00, 1'b1, 1'b1, OUT_NONE},
        // smallest nonzero rcode on the last byte itself
        '{8'h00, 1'b0, 1'b0, OUT_NONE},
        '{8'h00, 1'b0, 1'b0, OUT_NONE},
        '{8'h00, 1'b0, 1'b0, OUT_NONE},
        '{8'h01, 1'b1, 1'b1, OUT_NONE},
        // full header with zero question and answer counts
        '{8'hAB, 1'b0, 1'b0, OUT_NONE},
        '{8'hCD, 1'b0, 1'b0, OUT_NONE},
        '{8'h81, 1'b0, 1'b0, OUT_NONE},
        '{8'hF0, 1'b0, 1'b0, OUT_NONE},
        '{8'h00, 1'b0, 1'b0, OUT_NONE},
        '{8'h00, 1'b0, 1'b0, OUT_NONE},
        '{8'h00, 1'b0, 1'b0, OUT_NONE},
        '{8'h00, 1'b0, 1'b0, OUT_NONE},
        '{8'hFF, 1'b0, 1'b0, OUT_NONE},
        '{8'hFF, 1'b0, 1'b0, OUT_NONE},
        '{8'hFF, 1'b0, 1'b0, OUT_NONE},
        '{8'hFF, 1'b1, 1'b1, OUT_NONE}
    };

    logic i_clk;
    logic i_rst_n;

    dae_in_if  in_bus ();
    dae_out_if out_bus ();

    dns_answer_address_extractor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // Expected address results, oldest first
    t_addr_result addr_expect_q [$];
    int           err_cnt = 0;
    int           result_cnt = 0;
    int           stall_cycles = 0;

    // Idling knobs shared by the sender and the receiver
    int src_idle_pct = 30;
    int sink_idle_pct = 30;
    bit hold_req = 1'b0;

    // Packet under construction
    logic [7:0] pkt_bytes [$];

    // Parser state of the prediction
    logic [3:0]  hdr_pos;
    t_phase      ph;
    logic [15:0] qd_left;
    logic [15:0] an_left;
    logic [15:0] skip_cnt;
    logic [15:0] rr_type;
    logic [15:0] rd_len;
    logic [3:0]  fix_idx;
    logic [63:0] acc_hi;
    logic [63:0] acc_lo;
    t_outcome    verdict;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Address prediction
    // ------------------------------------------------------------------

    function automatic void clear_parser();
        hdr_pos  = '0;
        ph       = PH_HEADER;
        qd_left  = '0;
        an_left  = '0;
        skip_cnt = '0;
        rr_type  = '0;
        rd_len   = '0;
        fix_idx  = '0;
        acc_hi   = '0;
        acc_lo   = '0;
        verdict  = OUT_NONE;
    endfunction

    // Start the next question or answer name, or give up when none is left
    function automatic void open_record();
        if (qd_left != 0 || an_left != 0) begin
            ph = PH_LABEL;
        end else begin
            ph      = PH_DONE;
            verdict = OUT_FAIL;
        end
    endfunction

    function automatic void close_name();
        fix_idx = '0;
        ph      = (qd_left != 0) ? PH_QFIXED : PH_AFIXED;
    endfunction

    function automatic void close_answer();
        an_left = an_left - 16'd1;
        open_record();
    endfunction

    // Advance the parser by one packet byte
    function automatic void dns_parse_byte(input logic [7:0] b);
        logic [3:0] idx;
        case (ph)
            PH_HEADER: begin
                if (hdr_pos == HDR_RCODE && (b & RCODE_MASK) != 8'd0) begin
                    verdict = OUT_FAIL;
                    ph      = PH_DONE;
                end else begin
                    if (hdr_pos == HDR_QD_HI) qd_left[15:8] = b;
                    if (hdr_pos == HDR_QD_LO) qd_left[7:0]  = b;
                    if (hdr_pos == HDR_AN_HI) an_left[15:8] = b;
                    if (hdr_pos == HDR_AN_LO) an_left[7:0]  = b;
                    if (hdr_pos >= HDR_LAST) open_record();
                    else hdr_pos = hdr_pos + 4'd1;
                end
            end
            PH_LABEL: begin
                if ((b & PTR_MASK) == PTR_MASK) begin
                    ph = PH_PTR;
                end else if (b == 8'd0) begin
                    close_name();
                end else begin
                    skip_cnt = 16'(b);
                    ph       = PH_SKIP;
                end
            end
            PH_SKIP: begin
                skip_cnt = skip_cnt - 16'd1;
                if (skip_cnt == 0) ph = PH_LABEL;
            end
            PH_PTR: close_name();
            PH_QFIXED: begin
                fix_idx = fix_idx + 4'd1;
                if (fix_idx > QFIX_LAST) begin
                    qd_left = qd_left - 16'd1;
                    open_record();
                end
            end
            PH_AFIXED: begin
                if (fix_idx == AFIX_TYPE_HI) rr_type[15:8] = b;
                if (fix_idx == AFIX_TYPE_LO) rr_type[7:0]  = b;
                if (fix_idx == AFIX_LEN_HI)  rd_len[15:8]  = b;
                if (fix_idx == AFIX_LEN_LO)  rd_len[7:0]   = b;
                if (fix_idx < AFIX_LEN_LO) begin
                    fix_idx = fix_idx + 4'd1;
                end else if ((rr_type == TYPE_A && rd_len == LEN_A) ||
                             (rr_type == TYPE_AAAA && rd_len == LEN_AAAA)) begin
                    skip_cnt = rd_len;
                    acc_hi   = '0;
                    acc_lo   = '0;
                    ph       = PH_ADDR;
                end else if (rd_len == 0) begin
                    close_answer();
                end else begin
                    skip_cnt = rd_len;
                    ph       = PH_RDSKIP;
                end
            end
            PH_RDSKIP: begin
                skip_cnt = skip_cnt - 16'd1;
                if (skip_cnt == 0) close_answer();
            end
            PH_ADDR: begin
                idx = 4'(rd_len - skip_cnt);
                if (idx < 4'd8) acc_hi |= 64'(b) << (56 - 8 * idx);
                else            acc_lo |= 64'(b) << (56 - 8 * (idx - 4'd8));
                skip_cnt = skip_cnt - 16'd1;
                if (skip_cnt == 0) begin
                    verdict = (rd_len == LEN_A) ? OUT_V4 : OUT_V6;
                    ph      = PH_DONE;
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Packet construction
    // ------------------------------------------------------------------

    function automatic void push_random(input int n);
        for (int k = 0; k < n; k++) pkt_bytes.push_back(8'($urandom_range(255)));
    endfunction

    // Labels of random length, closed by a zero byte or a compression pointer
    function automatic void add_name();
        int n_lab;
        int len;
        n_lab = $urandom_range(0, 3);
        for (int k = 0; k < n_lab; k++) begin
            len = ($urandom_range(0, 39) == 0) ? $urandom_range(64, 191) : $urandom_range(1, 6);
            pkt_bytes.push_back(8'(len));
            push_random(len);
        end
        if ($urandom_range(0, 2) == 0) begin
            pkt_bytes.push_back(PTR_MASK | 8'($urandom_range(63)));
            push_random(1);
        end else begin
            pkt_bytes.push_back(8'd0);
        end
    endfunction

    function automatic void build_packet();
        int          kind;
        int          qd;
        int          an;
        int          sel;
        int          cut;
        logic [15:0] rtype;
        logic [15:0] rlen;
        pkt_bytes.delete();
        kind = $urandom_range(0, 99);
        if (kind >= 90) begin
            // pure noise
            push_random($urandom_range(1, 30));
        end else begin
            qd = $urandom_range(0, 2);
            an = ($urandom_range(0, 14) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3);
            push_random(3);
            if ($urandom_range(0, 9) == 0) push_random(1);
            else pkt_bytes.push_back({4'($urandom_range(15)), 4'b0});
            pkt_bytes.push_back(8'(qd >> 8));
            pkt_bytes.push_back(8'(qd));
            pkt_bytes.push_back(8'(an >> 8));
            pkt_bytes.push_back(8'(an));
            push_random(4);
            for (int k = 0; k < qd; k++) begin
                add_name();
                push_random(4);
            end
            for (int k = 0; k < an && k < 4; k++) begin
                add_name();
                sel = $urandom_range(0, 9);
                if (sel < 4) begin
                    rtype = TYPE_A;
                    rlen  = ($urandom_range(0, 4) != 0) ? LEN_A : 16'($urandom_range(0, 8));
                end else if (sel < 7) begin
                    rtype = TYPE_AAAA;
                    rlen  = ($urandom_range(0, 4) != 0) ? LEN_AAAA : 16'($urandom_range(0, 20));
                end else begin
                    rtype = 16'($urandom_range(0, 65535));
                    rlen  = ($urandom_range(0, 29) == 0) ? 16'($urandom_range(100, 300))
                                                         : 16'($urandom_range(0, 8));
                end
                pkt_bytes.push_back(rtype[15:8]);
                pkt_bytes.push_back(rtype[7:0]);
                push_random(6);
                pkt_bytes.push_back(rlen[15:8]);
                pkt_bytes.push_back(rlen[7:0]);
                push_random(int'(rlen));
            end
            push_random($urandom_range(0, 3));
            // broken packet: cut anywhere
            if (kind < 15) begin
                cut = $urandom_range(1, pkt_bytes.size());
                while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender: one beat per call, entered and left at a falling edge
    // ------------------------------------------------------------------

    task automatic push_byte(input logic [7:0] b, input logic last, input logic typed,
                             input t_outcome st);
        t_addr_result res;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.data_byte <= b;
        in_bus.last_byte <= last;
        // hold the beat until the block takes it
        do @(posedge i_clk); while (!in_bus.ready);
        dns_parse_byte(b);
        if (last) begin
            if (typed) begin
                res = '{st, 64'd0, 64'd0};
            end else if (verdict == OUT_V4 || verdict == OUT_V6) begin
                res = '{verdict, acc_hi, acc_lo};
            end else begin
                res = '{OUT_NONE, 64'd0, 64'd0};
            end
            addr_expect_q.push_back(res);
            clear_parser();
        end
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random ready, plus one long hold-off on request
    // ------------------------------------------------------------------

    initial begin
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                // stall the output so the byte queue fills behind it
                out_bus.ready <= 1'b0;
                hold_req = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                out_bus.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result check
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_addr_result want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            result_cnt++;
            if (addr_expect_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("result %0d arrived with no packet pending: status %0d",
                             result_cnt, out_bus.status);
            end else begin
                want = addr_expect_q.pop_front();
                if (out_bus.status !== want.status || out_bus.addr_high !== want.addr_high ||
                    out_bus.addr_low !== want.addr_low) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display({"result %0d mismatch: status %0d/%0d high %h/%h",
                                  " low %h/%h (expected/actual)"},
                                 result_cnt, want.status, out_bus.status,
                                 want.addr_high, out_bus.addr_high,
                                 want.addr_low, out_bus.addr_low);
                end
            end
        end
    end

    // Watchdog: count cycles in which no beat moves on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles, %0d results pending",
                     STALL_LIMIT, addr_expect_q.size());
            $display("** dns_answer_address_extractor: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        int sent_bytes;
        int pkt_cnt;
        sent_bytes = 0;
        pkt_cnt    = 0;
        i_rst_n           = 1'b0;
        in_bus.valid      = 1'b0;
        in_bus.data_byte  = 8'd0;
        in_bus.last_byte  = 1'b0;
        clear_parser();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed bytes: short and failing packets
        for (int r = 0; r < N_ROWS; r++)
            push_byte(STIM_ROWS[r].b, STIM_ROWS[r].last, STIM_ROWS[r].typed, STIM_ROWS[r].st);

        // random packets, mostly well formed
        while (sent_bytes < RAND_BYTES) begin
            if (pkt_cnt == HOLD_PACKET) hold_req = 1'b1;
            // no idling on either side for a stretch of a few hundred bytes
            src_idle_pct  = (sent_bytes >= QUIET_FROM && sent_bytes < QUIET_TO) ? 0 : 30;
            sink_idle_pct = src_idle_pct;
            build_packet();
            for (int k = 0; k < pkt_bytes.size(); k++)
                push_byte(pkt_bytes[k], k == pkt_bytes.size() - 1, 1'b0, OUT_NONE);
            sent_bytes += pkt_bytes.size();
            pkt_cnt++;
        end
        in_bus.valid <= 1'b0;

        // drain: the watchdog catches results that never come
        while (addr_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0)
            $display("** dns_answer_address_extractor: PASSED **");
        else
            $display("** dns_answer_address_extractor: FAILED **");
        $finish;
    end

endmodule
